// ===== sv/rpc_pkg.sv =====
// Shared constants, types and table functions of the rectangular/polar converter.
package rpc_pkg;

	localparam int CORDIC_STAGES = 16;
	localparam int FRACTION_BITS = 16;

	// x and y run as Q16.16 with this many guard bits below, in XW signed bits.
	localparam int GUARD_BITS = 16;
	localparam int XW = 50;

	localparam int DEG90_Q16 = 5898240;
	localparam int DEG180_Q16 = 11796480;
	localparam int DEG360_Q16 = 23592960;

	localparam longint Q_MAX = 64'sd2147483647;
	localparam longint Q_MIN = -64'sd2147483648;

	localparam logic [1:0] CMD_RECT = 2'd0;
	localparam logic [1:0] CMD_POLAR = 2'd1;

	// Per-item control that travels alongside the datapath.
	typedef struct packed {
		logic rotate;
		logic bad;
		logic zero;
		logic [31:0] first;
		logic [25:0] second;
	} side_t;

	// Arctangent of 2^-i in degrees, Q.24.
	localparam logic [31:0] ATAN_DEG_Q24 [32] = '{
		32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938, 32'd60000934,
		32'd30029717, 32'd15018523, 32'd7509720, 32'd3754917, 32'd1877466,
		32'd938734, 32'd469367, 32'd234684, 32'd117342, 32'd58671, 32'd29335,
		32'd14668, 32'd7334, 32'd3667, 32'd1833, 32'd917, 32'd458, 32'd229,
		32'd115, 32'd57, 32'd29, 32'd14, 32'd7, 32'd4, 32'd2, 32'd1, 32'd0
	};

	// Arctangent step rounded half up to fb fraction bits.
	function automatic logic [31:0] atan_step(input int i, input int fb);
		logic [32:0] t;
		t = {1'b0, ATAN_DEG_Q24[i & 31]};
		if (fb < 24) begin
			t = (t + (33'd1 << (23 - fb))) >> (24 - fb);
		end
		return t[31:0];
	endfunction

	// Inverse CORDIC gain for n stages, unsigned Q.32.
	function automatic logic [31:0] gain_k(input int n);
		logic [63:0] g;
		int m;
		m = (n < 8) ? 8 : ((n > 32) ? 32 : n);
		g = 64'd2608131496;
		if (m <= 20) begin
			g = g + ((64'd1738754331 + (64'd1 << (2 * m - 1))) >> (2 * m));
		end
		return g[31:0];
	endfunction

endpackage

// ===== sv/rpc_prep.sv =====
// Input conditioning: angle range reduction, quadrant folding and CORDIC start values.
module rpc_prep #(
	parameter int FB = rpc_pkg::FRACTION_BITS,
	parameter int ZW = rpc_pkg::FRACTION_BITS + 10
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic item_valid,
	input  logic [1:0] command,
	input  logic signed [31:0] first_value,
	input  logic signed [25:0] second_value,
	output logic valid_s2,
	output rpc_pkg::side_t side_s2,
	output logic signed [rpc_pkg::XW-1:0] x_s2,
	output logic signed [rpc_pkg::XW-1:0] y_s2,
	output logic signed [ZW-1:0] z_s2
);

	localparam int XW = rpc_pkg::XW;
	localparam int AW = 36;
	localparam int UP = (FB >= 16) ? FB - 16 : 0;
	localparam int DN = (FB < 16) ? 16 - FB : 0;
	localparam int RND = (DN > 0) ? (1 << (DN - 1)) : 0;

	// Degrees Q16.16 to the accumulator format, rounded half up.
	function automatic logic signed [ZW-1:0] angle_in(input logic signed [25:0] a);
		logic signed [AW-1:0] w;
		w = AW'(a);
		w = ((w <<< UP) + AW'(RND)) >>> DN;
		return ZW'(w);
	endfunction

	logic valid_s1;
	rpc_pkg::side_t side_s1;
	logic signed [25:0] a_s1;

	logic signed [26:0] a_in;
	logic signed [26:0] a_red;
	rpc_pkg::side_t side_d;

	always_comb begin
		a_in = 27'(second_value);
		// One turn is enough: the field spans less than 540 degrees either way.
		if (a_in > 27'(rpc_pkg::DEG180_Q16)) begin
			a_red = a_in - 27'(rpc_pkg::DEG360_Q16);
		end else if (a_in <= -27'(rpc_pkg::DEG180_Q16)) begin
			a_red = a_in + 27'(rpc_pkg::DEG360_Q16);
		end else begin
			a_red = a_in;
		end
		side_d.rotate = (command == rpc_pkg::CMD_POLAR);
		side_d.bad = (command != rpc_pkg::CMD_RECT) && (command != rpc_pkg::CMD_POLAR);
		side_d.zero = (first_value == 32'sd0) && (second_value == 26'sd0);
		side_d.first = first_value;
		side_d.second = second_value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= item_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_d;
			a_s1 <= 26'(a_red);
		end
	end

	logic signed [26:0] a_fold;
	logic flip;
	logic signed [XW-1:0] p1;
	logic signed [XW-1:0] p2;
	logic signed [XW-1:0] x_d;
	logic signed [XW-1:0] y_d;
	logic signed [ZW-1:0] z_d;

	always_comb begin
		p1 = XW'($signed(side_s1.first));
		p2 = XW'($signed(side_s1.second));
		a_fold = 27'(a_s1);
		flip = 1'b0;
		// Angles beyond a quarter turn rotate by half a turn and negate the radius.
		if (a_fold > 27'(rpc_pkg::DEG90_Q16)) begin
			a_fold = a_fold - 27'(rpc_pkg::DEG180_Q16);
			flip = 1'b1;
		end else if (a_fold < -27'(rpc_pkg::DEG90_Q16)) begin
			a_fold = a_fold + 27'(rpc_pkg::DEG180_Q16);
			flip = 1'b1;
		end
		if (side_s1.rotate) begin
			x_d = (flip ? -p1 : p1) <<< rpc_pkg::GUARD_BITS;
			y_d = '0;
			z_d = angle_in(26'(a_fold));
		end else if (p1 < 0) begin
			// Vectors in the left half plane start half a turn around.
			x_d = (-p1) <<< rpc_pkg::GUARD_BITS;
			y_d = (-p2) <<< rpc_pkg::GUARD_BITS;
			z_d = (p2 >= 0) ? angle_in(26'(rpc_pkg::DEG180_Q16))
				: angle_in(-26'(rpc_pkg::DEG180_Q16));
		end else begin
			x_d = p1 <<< rpc_pkg::GUARD_BITS;
			y_d = p2 <<< rpc_pkg::GUARD_BITS;
			z_d = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2 <= side_s1;
			x_s2 <= x_d;
			y_s2 <= y_d;
			z_s2 <= z_d;
		end
	end

endmodule

// ===== sv/rpc_cell.sv =====
// One CORDIC micro-rotation cell with its pipeline register.
module rpc_cell #(
	parameter int STAGE = 0,
	parameter int FB = rpc_pkg::FRACTION_BITS,
	parameter int ZW = rpc_pkg::FRACTION_BITS + 10
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic valid_in,
	input  rpc_pkg::side_t side_in,
	input  logic signed [rpc_pkg::XW-1:0] x_in,
	input  logic signed [rpc_pkg::XW-1:0] y_in,
	input  logic signed [ZW-1:0] z_in,
	output logic valid_q,
	output rpc_pkg::side_t side_q,
	output logic signed [rpc_pkg::XW-1:0] x_q,
	output logic signed [rpc_pkg::XW-1:0] y_q,
	output logic signed [ZW-1:0] z_q
);

	localparam int XW = rpc_pkg::XW;
	localparam logic signed [ZW-1:0] ATAN = ZW'(rpc_pkg::atan_step(STAGE, FB));

	logic pos;
	logic signed [XW-1:0] x_sh;
	logic signed [XW-1:0] y_sh;

	// Rotation drives the angle toward zero; vectoring drives y toward zero.
	assign pos = side_in.rotate ? !z_in[ZW-1] : y_in[XW-1];
	assign x_sh = x_in >>> STAGE;
	assign y_sh = y_in >>> STAGE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q <= side_in;
			x_q <= pos ? x_in - y_sh : x_in + y_sh;
			y_q <= pos ? y_in + x_sh : y_in - x_sh;
			z_q <= pos ? z_in - ATAN : z_in + ATAN;
		end
	end

endmodule

// ===== sv/rpc_gain.sv =====
// Gain correction, guard bit removal and Q16.16 saturation for one coordinate.
module rpc_gain #(
	parameter logic [31:0] K = 32'd2608131496
) (
	input  logic clk,
	input  logic en,
	input  logic signed [rpc_pkg::XW-1:0] v,
	output logic [31:0] result,
	output logic sat
);

	localparam int MW = rpc_pkg::XW - 1;
	localparam int PW = MW + 1;

	logic neg_s1;
	logic neg_s2;
	logic neg_s3;
	logic [MW-1:0] mag_s1;
	logic [63:0] plo_s2;
	logic [MW-1:0] phi_s2;
	logic [PW-1:0] p_s3;
	logic [64:0] lo_rnd;

	assign lo_rnd = {1'b0, plo_s2} + 65'h0_8000_0000;

	// Magnitude times K, split into a low and a high partial product.
	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= v[rpc_pkg::XW-1];
			mag_s1 <= MW'(v[rpc_pkg::XW-1] ? -v : v);
			neg_s2 <= neg_s1;
			plo_s2 <= mag_s1[31:0] * K;
			phi_s2 <= mag_s1[MW-1:32] * K;
			neg_s3 <= neg_s2;
			p_s3 <= PW'(phi_s2) + PW'(lo_rnd[64:32]);
		end
	end

	logic signed [PW:0] sv;
	logic signed [PW:0] dropped;

	always_comb begin
		sv = neg_s3 ? -$signed({1'b0, p_s3}) : $signed({1'b0, p_s3});
		dropped = (sv + (PW + 1)'(1 << (rpc_pkg::GUARD_BITS - 1))) >>> rpc_pkg::GUARD_BITS;
		if (dropped > rpc_pkg::Q_MAX) begin
			result = 32'h7FFF_FFFF;
			sat = 1'b1;
		end else if (dropped < rpc_pkg::Q_MIN) begin
			result = 32'h8000_0000;
			sat = 1'b1;
		end else begin
			result = dropped[31:0];
			sat = 1'b0;
		end
	end

endmodule

// ===== sv/rect_polar_converter_unit.sv =====
// Rectangular/polar converter top level: CORDIC cell chain with gain and output stages.
//
// Item channel (item_valid/item_ready) carries command, first_value and second_value.
// Rectangular command: x and y in, length and atan2 angle in degrees out, inputs echoed.
// Polar command: radius and angle in, x and y out, radius and angle echoed.
// Other commands return a zeroed result with bad_mode set.
// Result channel (result_valid/result_ready) returns one transaction per item.
//
// The pipeline holds two conditioning stages, one cell per micro-rotation,
// three gain multiply stages and the output register. Throughput is one
// item per cycle unless the receiver stalls; the whole pipeline advances together.
// When the receiver stalls with a result waiting, the pipeline holds and
// item_ready drops in the same cycle; it returns when the result is taken.
// Reset empties the pipeline; no result is pending afterwards and the block
// accepts an item in the first cycle after reset is released.
module rect_polar_converter_unit #(
	parameter int CORDIC_STAGES = rpc_pkg::CORDIC_STAGES,
	parameter int FRACTION_BITS = rpc_pkg::FRACTION_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_ready,
	input  logic [1:0] command,
	input  logic signed [31:0] first_value,
	input  logic signed [25:0] second_value,
	output logic result_valid,
	input  logic result_ready,
	output logic signed [31:0] x_coord,
	output logic signed [31:0] y_coord,
	output logic signed [31:0] magnitude,
	output logic signed [25:0] angle_degrees,
	output logic mode_out,
	output logic bad_mode,
	output logic saturated
);

	localparam int STAGES = (CORDIC_STAGES < 8) ? 8
		: ((CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES);
	localparam int FB = (FRACTION_BITS < 8) ? 8 : ((FRACTION_BITS > 24) ? 24 : FRACTION_BITS);
	localparam int ZW = FB + 10;
	localparam int OW = ZW + 9;
	localparam int XW = rpc_pkg::XW;
	localparam logic [31:0] K = rpc_pkg::gain_k(STAGES);
	localparam int UPO = (FB < 16) ? 16 - FB : 0;
	localparam int DNO = (FB > 16) ? FB - 16 : 0;
	localparam int RNDO = (DNO > 0) ? (1 << (DNO - 1)) : 0;

	logic en;
	logic result_valid_q;

	assign en = !result_valid_q || result_ready;
	assign item_ready = en;

	logic valid_c [STAGES+1];
	rpc_pkg::side_t side_c [STAGES+1];
	logic signed [XW-1:0] x_c [STAGES+1];
	logic signed [XW-1:0] y_c [STAGES+1];
	logic signed [ZW-1:0] z_c [STAGES+1];

	rpc_prep #(
		.FB(FB),
		.ZW(ZW)
	) u_prep (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.item_valid(item_valid),
		.command(command),
		.first_value(first_value),
		.second_value(second_value),
		.valid_s2(valid_c[0]),
		.side_s2(side_c[0]),
		.x_s2(x_c[0]),
		.y_s2(y_c[0]),
		.z_s2(z_c[0])
	);

	for (genvar i = 0; i < STAGES; i++) begin : g_cell
		rpc_cell #(
			.STAGE(i),
			.FB(FB),
			.ZW(ZW)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.valid_in(valid_c[i]),
			.side_in(side_c[i]),
			.x_in(x_c[i]),
			.y_in(y_c[i]),
			.z_in(z_c[i]),
			.valid_q(valid_c[i+1]),
			.side_q(side_c[i+1]),
			.x_q(x_c[i+1]),
			.y_q(y_c[i+1]),
			.z_q(z_c[i+1])
		);
	end

	logic [31:0] res_x;
	logic [31:0] res_y;
	logic sat_x;
	logic sat_y;

	rpc_gain #(
		.K(K)
	) u_gain_x (
		.clk(clk),
		.en(en),
		.v(x_c[STAGES]),
		.result(res_x),
		.sat(sat_x)
	);

	rpc_gain #(
		.K(K)
	) u_gain_y (
		.clk(clk),
		.en(en),
		.v(y_c[STAGES]),
		.result(res_y),
		.sat(sat_y)
	);

	// Accumulated angle back to degrees Q16.16, clamped to a half turn.
	logic signed [OW-1:0] z_out;
	logic signed [25:0] ang_d;

	always_comb begin
		z_out = ((OW'(z_c[STAGES]) <<< UPO) + OW'(RNDO)) >>> DNO;
		if (z_out > OW'(rpc_pkg::DEG180_Q16)) begin
			ang_d = 26'(rpc_pkg::DEG180_Q16);
		end else if (z_out < -OW'(rpc_pkg::DEG180_Q16)) begin
			ang_d = -26'(rpc_pkg::DEG180_Q16);
		end else begin
			ang_d = 26'(z_out);
		end
	end

	// Side information and angle wait here while the gain stages multiply.
	logic valid_s1;
	logic valid_s2;
	logic valid_s3;
	rpc_pkg::side_t side_s1;
	rpc_pkg::side_t side_s2;
	rpc_pkg::side_t side_s3;
	logic signed [25:0] ang_s1;
	logic signed [25:0] ang_s2;
	logic signed [25:0] ang_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			result_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_c[STAGES];
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			result_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_c[STAGES];
			side_s2 <= side_s1;
			side_s3 <= side_s2;
			ang_s1 <= ang_d;
			ang_s2 <= ang_s1;
			ang_s3 <= ang_s2;
		end
	end

	logic [31:0] x_d;
	logic [31:0] y_d;
	logic [31:0] mag_d;
	logic [25:0] angle_d;
	logic mode_d;
	logic bad_d;
	logic sat_d;

	always_comb begin
		x_d = '0;
		y_d = '0;
		mag_d = '0;
		angle_d = '0;
		mode_d = 1'b0;
		bad_d = 1'b0;
		sat_d = 1'b0;
		if (side_s3.bad) begin
			bad_d = 1'b1;
		end else if (side_s3.rotate) begin
			x_d = res_x;
			y_d = res_y;
			mag_d = side_s3.first;
			angle_d = side_s3.second;
			mode_d = 1'b1;
			sat_d = sat_x || sat_y;
		end else begin
			x_d = side_s3.first;
			y_d = 32'($signed(side_s3.second));
			// The zero vector has no direction; both results are reported as zero.
			if (!side_s3.zero) begin
				mag_d = res_x;
				angle_d = ang_s3;
				sat_d = sat_x;
			end
		end
	end

	logic [31:0] x_coord_q;
	logic [31:0] y_coord_q;
	logic [31:0] magnitude_q;
	logic [25:0] angle_degrees_q;
	logic mode_out_q;
	logic bad_mode_q;
	logic saturated_q;

	always_ff @(posedge clk) begin
		if (en) begin
			x_coord_q <= x_d;
			y_coord_q <= y_d;
			magnitude_q <= mag_d;
			angle_degrees_q <= angle_d;
			mode_out_q <= mode_d;
			bad_mode_q <= bad_d;
			saturated_q <= sat_d;
		end
	end

	assign result_valid = result_valid_q;
	assign x_coord = $signed(x_coord_q);
	assign y_coord = $signed(y_coord_q);
	assign magnitude = $signed(magnitude_q);
	assign angle_degrees = $signed(angle_degrees_q);
	assign mode_out = mode_out_q;
	assign bad_mode = bad_mode_q;
	assign saturated = saturated_q;

endmodule

// ===== tb/sv/tb_rect_polar_converter_unit.sv =====
// Self-checking testbench of the rectangular/polar CORDIC converter with a bit-exact predictor.
module tb_rect_polar_converter_unit;

	localparam int LIMIT_CYCLES = 200000;
	localparam int RANDOM_ITEMS = 800;

	localparam logic [1:0] CMD_INVALID_LO = 2'd2;
	localparam logic [1:0] CMD_INVALID_HI = 2'd3;

	// Stage count and angle accumulator fraction bits, clamped as the block uses them.
	localparam int N_ROT = (rpc_pkg::CORDIC_STAGES < 8) ? 8 :
		((rpc_pkg::CORDIC_STAGES > 32) ? 32 : rpc_pkg::CORDIC_STAGES);
	localparam int ACC_FRAC = (rpc_pkg::FRACTION_BITS < 8) ? 8 :
		((rpc_pkg::FRACTION_BITS > 24) ? 24 : rpc_pkg::FRACTION_BITS);

	// Inverse CORDIC gain, unsigned Q.32.
	localparam logic [63:0] GAIN_WIDE = 64'd2608131496 + ((N_ROT <= 20) ?
		((64'd1738754331 + (64'd1 << (2 * N_ROT - 1))) >> (2 * N_ROT)) : 64'd0);
	localparam logic [31:0] GAIN_Q32 = GAIN_WIDE[31:0];

	// Arctangent of 2^-i in degrees, Q.24.
	localparam longint ATAN_Q24 [32] = '{
		754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
		15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684,
		117342, 58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229,
		115, 57, 29, 14, 7, 4, 2, 1, 0
	};

	localparam logic [25:0] ANG_90 = 26'(rpc_pkg::DEG90_Q16);
	localparam logic [25:0] ANG_180 = 26'(rpc_pkg::DEG180_Q16);
	localparam logic [25:0] ANG_360 = 26'(rpc_pkg::DEG360_Q16);

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] mag;
		logic [25:0] ang;
		logic mode;
		logic bad;
		logic sat;
	} coord_result_t;

	typedef struct {
		logic [1:0] cmd;
		logic [31:0] first;
		logic [25:0] second;
		bit known;
		coord_result_t want;
	} conv_item_t;

	localparam coord_result_t BAD_RESULT = '{x: 32'd0, y: 32'd0, mag: 32'd0, ang: 26'd0,
		mode: 1'b0, bad: 1'b1, sat: 1'b0};
	localparam coord_result_t ZERO_RECT = '{x: 32'd0, y: 32'd0, mag: 32'd0, ang: 26'd0,
		mode: 1'b0, bad: 1'b0, sat: 1'b0};

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_ready;
	logic [1:0] command;
	logic signed [31:0] first_value;
	logic signed [25:0] second_value;
	logic result_valid;
	logic result_ready;
	logic signed [31:0] x_coord;
	logic signed [31:0] y_coord;
	logic signed [31:0] magnitude;
	logic signed [25:0] angle_degrees;
	logic mode_out;
	logic bad_mode;
	logic saturated;

	conv_item_t send_list[$];
	coord_result_t pending_results[$];
	conv_item_t offered;
	int next_index = 0;
	int accepted_count = 0;
	int rect_count = 0;
	int polar_count = 0;
	int invalid_count = 0;
	int clipped_count = 0;
	int error_count = 0;
	int cycle_count = 0;
	logic steady;

	rect_polar_converter_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.command(command),
		.first_value(first_value),
		.second_value(second_value),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.x_coord(x_coord),
		.y_coord(y_coord),
		.magnitude(magnitude),
		.angle_degrees(angle_degrees),
		.mode_out(mode_out),
		.bad_mode(bad_mode),
		.saturated(saturated)
	);

	function automatic longint atan_step_acc(input int i);
		longint t;
		t = ATAN_Q24[i];
		if (ACC_FRAC < 24) begin
			t = (t + (64'sd1 <<< (23 - ACC_FRAC))) >>> (24 - ACC_FRAC);
		end
		return t;
	endfunction

	// Degrees Q16.16 into the accumulator format, rounding half up.
	function automatic longint deg_to_acc(input longint a);
		if (ACC_FRAC >= 16) begin
			return a * (64'sd1 <<< (ACC_FRAC - 16));
		end
		return (a + (64'sd1 <<< (15 - ACC_FRAC))) >>> (16 - ACC_FRAC);
	endfunction

	// Gain correction rounded half away from zero, then guard bits dropped half up.
	function automatic longint to_q16(input longint v);
		logic [63:0] m;
		logic [95:0] prod;
		longint g;
		m = (v < 0) ? 64'(-v) : 64'(v);
		prod = 96'(m) * 96'(GAIN_Q32) + 96'h8000_0000;
		g = longint'(prod[95:32]);
		if (v < 0) begin
			g = -g;
		end
		return (g + 64'sd32768) >>> 16;
	endfunction

	// Returns the clip flag above the saturated 32-bit value.
	function automatic logic [32:0] clip_q16(input longint v);
		if (v > rpc_pkg::Q_MAX) begin
			return {1'b1, 32'h7FFF_FFFF};
		end
		if (v < rpc_pkg::Q_MIN) begin
			return {1'b1, 32'h8000_0000};
		end
		return {1'b0, v[31:0]};
	endfunction

	function automatic coord_result_t convert_item(input logic [1:0] cmd, input logic [31:0] f,
			input logic [25:0] s);
		coord_result_t r;
		longint p1, p2, x, y, z, nx, ny, a, rad;
		logic [32:0] c;
		r = '0;
		p1 = $signed(f);
		p2 = $signed(s);
		if (cmd != rpc_pkg::CMD_RECT && cmd != rpc_pkg::CMD_POLAR) begin
			r.bad = 1'b1;
			return r;
		end
		if (cmd == rpc_pkg::CMD_RECT) begin
			r.x = f;
			r.y = p2[31:0];
			if (p1 == 0 && p2 == 0) begin
				return r;
			end
			x = p1 * 65536;
			y = p2 * 65536;
			z = 0;
			// A vector in the left half plane is first turned around by 180 degrees.
			if (x < 0) begin
				x = -x;
				y = -y;
				z = deg_to_acc((p2 >= 0) ? longint'(rpc_pkg::DEG180_Q16)
					: -longint'(rpc_pkg::DEG180_Q16));
			end
			for (int i = 0; i < N_ROT; i++) begin
				if (y >= 0) begin
					nx = x + (y >>> i);
					ny = y - (x >>> i);
					z = z + atan_step_acc(i);
				end else begin
					nx = x - (y >>> i);
					ny = y + (x >>> i);
					z = z - atan_step_acc(i);
				end
				x = nx;
				y = ny;
			end
			c = clip_q16(to_q16(x));
			r.mag = c[31:0];
			r.sat = c[32];
			if (ACC_FRAC > 16) begin
				z = (z + (64'sd1 <<< (ACC_FRAC - 17))) >>> (ACC_FRAC - 16);
			end else begin
				z = z * (64'sd1 <<< (16 - ACC_FRAC));
			end
			if (z > rpc_pkg::DEG180_Q16) begin
				z = rpc_pkg::DEG180_Q16;
			end
			if (z < -rpc_pkg::DEG180_Q16) begin
				z = -rpc_pkg::DEG180_Q16;
			end
			r.ang = z[25:0];
		end else begin
			r.mode = 1'b1;
			r.mag = f;
			r.ang = s;
			a = p2;
			rad = p1;
			while (a > rpc_pkg::DEG180_Q16) begin
				a = a - rpc_pkg::DEG360_Q16;
			end
			while (a <= -rpc_pkg::DEG180_Q16) begin
				a = a + rpc_pkg::DEG360_Q16;
			end
			// Angles past a right angle rotate the negated radius by the supplement.
			if (a > rpc_pkg::DEG90_Q16) begin
				a = a - rpc_pkg::DEG180_Q16;
				rad = -rad;
			end else if (a < -rpc_pkg::DEG90_Q16) begin
				a = a + rpc_pkg::DEG180_Q16;
				rad = -rad;
			end
			x = rad * 65536;
			y = 0;
			z = deg_to_acc(a);
			for (int i = 0; i < N_ROT; i++) begin
				if (z >= 0) begin
					nx = x - (y >>> i);
					ny = y + (x >>> i);
					z = z - atan_step_acc(i);
				end else begin
					nx = x + (y >>> i);
					ny = y - (x >>> i);
					z = z + atan_step_acc(i);
				end
				x = nx;
				y = ny;
			end
			c = clip_q16(to_q16(x));
			r.x = c[31:0];
			r.sat = c[32];
			c = clip_q16(to_q16(y));
			r.y = c[31:0];
			r.sat = r.sat | c[32];
		end
		return r;
	endfunction

	function automatic logic [31:0] spread_bits(input int min_shift);
		logic signed [31:0] v;
		v = $urandom;
		return v >>> $urandom_range(31, min_shift);
	endfunction

	task automatic add_row(input logic [1:0] cmd, input logic [31:0] f, input logic [25:0] s);
		conv_item_t it;
		it.cmd = cmd;
		it.first = f;
		it.second = s;
		it.known = 1'b0;
		it.want = '0;
		send_list.push_back(it);
	endtask

	task automatic add_known(input logic [1:0] cmd, input logic [31:0] f,
			input logic [25:0] s, input coord_result_t want);
		conv_item_t it;
		it.cmd = cmd;
		it.first = f;
		it.second = s;
		it.known = 1'b1;
		it.want = want;
		send_list.push_back(it);
	endtask

	task automatic build_send_list();
		int pick;
		logic [1:0] cmd;
		logic [31:0] f;
		logic [25:0] s;
		coord_result_t zero_polar;
		zero_polar = '{x: 32'd0, y: 32'd0, mag: 32'd0, ang: ANG_90, mode: 1'b1, bad: 1'b0,
			sat: 1'b0};
		add_known(CMD_INVALID_LO, 32'h7FFF_FFFF, 26'h1FF_FFFF, BAD_RESULT);
		add_known(CMD_INVALID_HI, 32'h8000_0000, 26'h200_0000, BAD_RESULT);
		add_known(rpc_pkg::CMD_RECT, 32'd0, 26'd0, ZERO_RECT);
		add_known(rpc_pkg::CMD_POLAR, 32'd0, ANG_90, zero_polar);
		zero_polar.ang = -ANG_360;
		add_known(rpc_pkg::CMD_POLAR, 32'd0, -ANG_360, zero_polar);
		add_row(rpc_pkg::CMD_RECT, 32'h7FFF_FFFF, 26'h1FF_FFFF);
		add_row(rpc_pkg::CMD_RECT, 32'h8000_0000, 26'h200_0000);
		add_row(rpc_pkg::CMD_RECT, 32'h8000_0000, 26'd0);
		add_row(rpc_pkg::CMD_RECT, 32'(-65536), 26'd0);
		add_row(rpc_pkg::CMD_RECT, 32'(-65536), 26'h3FF_FFFF);
		add_row(rpc_pkg::CMD_RECT, 32'd0, 26'd65536);
		add_row(rpc_pkg::CMD_RECT, 32'd0, 26'(-65536));
		add_row(rpc_pkg::CMD_RECT, 32'd196608, 26'd262144);
		add_row(rpc_pkg::CMD_RECT, 32'd1, 26'd1);
		add_row(rpc_pkg::CMD_POLAR, 32'h7FFF_FFFF, 26'd0);
		add_row(rpc_pkg::CMD_POLAR, 32'h8000_0000, 26'd0);
		add_row(rpc_pkg::CMD_POLAR, 32'd65536, ANG_180);
		add_row(rpc_pkg::CMD_POLAR, 32'd65536, -ANG_180);
		add_row(rpc_pkg::CMD_POLAR, 32'd65536, ANG_360);
		add_row(rpc_pkg::CMD_POLAR, 32'(-327680), ANG_90 >> 1);
		add_row(rpc_pkg::CMD_POLAR, 32'd65536, 26'h1FF_FFFF);
		add_row(rpc_pkg::CMD_POLAR, 32'd65536, 26'h200_0000);
		add_row(rpc_pkg::CMD_POLAR, 32'h7FFF_FFFF, ANG_90 >> 1);
		add_row(rpc_pkg::CMD_POLAR, 32'd131072, ANG_90 + 26'd65536);
		add_row(rpc_pkg::CMD_POLAR, 32'd131072, -ANG_90);
		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			pick = $urandom_range(99);
			if (pick < 45) begin
				cmd = rpc_pkg::CMD_RECT;
			end else if (pick < 90) begin
				cmd = rpc_pkg::CMD_POLAR;
			end else begin
				cmd = $urandom_range(1) ? CMD_INVALID_HI : CMD_INVALID_LO;
			end
			f = spread_bits(0);
			if (cmd == rpc_pkg::CMD_POLAR && $urandom_range(9) != 0) begin
				s = 26'(int'($urandom_range(2 * rpc_pkg::DEG360_Q16)) - rpc_pkg::DEG360_Q16);
			end else begin
				s = 26'(spread_bits(6));
			end
			if (cmd == rpc_pkg::CMD_RECT && $urandom_range(39) == 0) begin
				f = 32'd0;
				s = 26'd0;
			end
			add_row(cmd, f, s);
		end
	endtask

	task automatic check_field(input string label, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) begin
			$display("%0t: %s expected %h, got %h", $time, label, want, got);
			error_count++;
		end
	endtask

	task automatic check_result();
		coord_result_t want;
		if (pending_results.size() == 0) begin
			$display("%0t: result transaction with no item awaiting it", $time);
			error_count++;
		end else begin
			want = pending_results.pop_front();
			check_field("x_coord", x_coord, want.x);
			check_field("y_coord", y_coord, want.y);
			check_field("magnitude", magnitude, want.mag);
			check_field("angle_degrees", {6'd0, angle_degrees}, {6'd0, want.ang});
			check_field("mode_out", 32'(mode_out), 32'(want.mode));
			check_field("bad_mode", 32'(bad_mode), 32'(want.bad));
			check_field("saturated", 32'(saturated), 32'(want.sat));
		end
		if (saturated === 1'b1) begin
			clipped_count++;
		end
	endtask

	initial begin
		clk = 1'b0;
		forever begin
			#10 clk = ~clk;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("%0t: run exceeded %0d cycles", $time, LIMIT_CYCLES);
			$display("** rect_polar_converter_unit: FAILED **");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			// Neither side stalls over a stretch in the middle of the run.
			steady = accepted_count >= 300 && accepted_count < 450;
			if (result_valid && result_ready) begin
				check_result();
			end
			if (item_valid && item_ready) begin
				if (offered.known) begin
					pending_results.push_back(offered.want);
				end else begin
					pending_results.push_back(convert_item(offered.cmd, offered.first,
						offered.second));
				end
				accepted_count++;
				if (offered.cmd == rpc_pkg::CMD_RECT) begin
					rect_count++;
				end else if (offered.cmd == rpc_pkg::CMD_POLAR) begin
					polar_count++;
				end else begin
					invalid_count++;
				end
			end
			if (!item_valid || item_ready) begin
				if (next_index < send_list.size() && (steady || $urandom_range(99) >= 30)) begin
					offered = send_list[next_index];
					next_index++;
					item_valid <= 1'b1;
					command <= offered.cmd;
					first_value <= offered.first;
					second_value <= offered.second;
				end else begin
					item_valid <= 1'b0;
				end
			end
			result_ready <= steady || ($urandom_range(99) >= 30);
		end
	end

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		command = rpc_pkg::CMD_RECT;
		first_value = '0;
		second_value = '0;
		result_ready = 1'b0;
		steady = 1'b0;
		offered = '{cmd: rpc_pkg::CMD_RECT, first: 32'd0, second: 26'd0, known: 1'b0,
			want: '0};
		build_send_list();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		while (accepted_count < send_list.size()) begin
			@(posedge clk);
		end
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (rpc_pkg::CORDIC_STAGES + 12) @(posedge clk);
		$display("Converted %0d rectangular, %0d polar and %0d invalid transactions, %0d clipped.",
			rect_count, polar_count, invalid_count, clipped_count);
		$display("Both channels stalled at random apart from one stall-free stretch.");
		if (error_count == 0) begin
			$display("** rect_polar_converter_unit: PASSED **");
		end else begin
			$display("** rect_polar_converter_unit: FAILED **");
		end
		$finish;
	end

endmodule

// ===== rect_polar_converter_unit.f =====
sv/rpc_pkg.sv
sv/rpc_prep.sv
sv/rpc_cell.sv
sv/rpc_gain.sv
sv/rect_polar_converter_unit.sv
tb/sv/tb_rect_polar_converter_unit.sv
